FILE: hw/rtl/ogeu_pkg.sv
// Shared types, constants and helpers for the occupancy grid evidence update core.
// Holds grid geometry, cell entry layout, command and class codes, and the controller states.
// Depends on nothing; ogeu_coord, ogeu_eval and the top level import it.
package ogeu_pkg;

    // Grid geometry
    localparam int COLS        = 14;
    localparam int ROWS        = 7;
    localparam int PRECISION   = 8;
    localparam int COUNT_WIDTH = 16;

    localparam int GRID_W      = COLS * PRECISION * 2;
    localparam int GRID_H      = ROWS * PRECISION * 2;
    localparam int CELLS       = GRID_W * GRID_H;
    localparam int CELL_ADDR_W = $clog2(CELLS);
    localparam int CX_W        = $clog2(GRID_W);
    localparam int CY_W        = $clog2(GRID_H);

    // Position arithmetic: Q8.8 times PRECISION/2 means a divide by 512 after scaling
    localparam int POS_W       = 16;
    localparam int T_W         = 24;
    localparam int ROUND_SHIFT = 9;
    localparam int ROUND_HALF  = 256;
    localparam int X_OFS       = COLS * PRECISION * 512;
    localparam int Y_OFS       = ROWS * PRECISION * 512;

    // Origin cell, the reset value of the last visited cell
    localparam logic [CX_W-1:0] ORIGIN_X = CX_W'(COLS * PRECISION);
    localparam logic [CY_W-1:0] ORIGIN_Y = CY_W'(ROWS * PRECISION);

    // Configuration registers
    localparam int RATIO_W   = 8;
    localparam int CFG_IDX_W = 1;
    localparam logic [RATIO_W-1:0] RATIO_NUM_RST = RATIO_W'(3);
    localparam logic [RATIO_W-1:0] RATIO_DEN_RST = RATIO_W'(20);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATIO_NUM = 1'b0,
        CFG_RATIO_DEN = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CMD_WALL   = 2'd0,
        CMD_GROUND = 2'd1,
        CMD_VISIT  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        CLS_UNKNOWN = 2'd0,
        CLS_GROUND  = 2'd1,
        CLS_WALL    = 2'd2
    } cell_class_t;

    typedef logic [COUNT_WIDTH-1:0] cnt_t;

    localparam int PROD_W = COUNT_WIDTH + RATIO_W;

    // One grid cell as stored in memory
    typedef struct packed {
        cell_class_t cls;
        cnt_t        wall;
        cnt_t        ground;
        cnt_t        visit;
    } cell_entry_t;

    localparam int ENTRY_W = $bits(cell_entry_t);

    // Mapped grid position of one item
    typedef struct packed {
        logic            ok;
        logic [CX_W-1:0] cx;
        logic [CY_W-1:0] cy;
    } cell_pos_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MODIFY,
        ST_MULT,
        ST_WRITE
    } ctrl_state_t;

    // Saturating increment of an evidence counter
    function automatic cnt_t sat_inc(input cnt_t c);
        return (c == '1) ? c : c + cnt_t'(1);
    endfunction

endpackage

FILE: hw/rtl/ogeu_cell_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// Holds the per-cell evidence store; no dependencies.
module ogeu_cell_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/ogeu_coord.sv
// Maps a Q8.8 world position to a grid cell with half-away-from-zero rounding
// and checks grid bounds and command code. Depends on ogeu_pkg.
module ogeu_coord (
    input  logic [1:0]                    command,
    input  logic signed [15:0]            pos_x,
    input  logic signed [15:0]            pos_y,
    output ogeu_pkg::cell_pos_t           pos
);
    import ogeu_pkg::*;

    localparam int M_W = T_W - ROUND_SHIFT;

    logic signed [T_W-1:0] px_ext;
    logic signed [T_W-1:0] py_ext;
    logic signed [T_W-1:0] tx;
    logic signed [T_W-1:0] ty;
    logic [T_W-1:0]        mag_x;
    logic [T_W-1:0]        mag_y;
    logic [M_W-1:0]        mx;
    logic [M_W-1:0]        my;
    logic                  x_ok;
    logic                  y_ok;
    logic                  cmd_ok;

    // Scale and offset into grid units times 512
    always_comb
    begin
        px_ext = T_W'(pos_x);
        py_ext = T_W'(pos_y);
        tx     = px_ext * signed'(T_W'(PRECISION)) + signed'(T_W'(X_OFS));
        ty     = signed'(T_W'(Y_OFS)) - py_ext * signed'(T_W'(PRECISION));
    end

    // Round the magnitude; a negative value only lands on the grid when it rounds to zero
    always_comb
    begin
        mag_x  = tx[T_W-1] ? T_W'(-tx) : T_W'(tx);
        mag_y  = ty[T_W-1] ? T_W'(-ty) : T_W'(ty);
        mx     = M_W'((mag_x + T_W'(ROUND_HALF)) >> ROUND_SHIFT);
        my     = M_W'((mag_y + T_W'(ROUND_HALF)) >> ROUND_SHIFT);
        x_ok   = tx[T_W-1] ? (mx == '0) : (mx < M_W'(GRID_W));
        y_ok   = ty[T_W-1] ? (my == '0) : (my < M_W'(GRID_H));
        cmd_ok = (command == CMD_WALL) || (command == CMD_GROUND) || (command == CMD_VISIT);
        pos.ok = x_ok && y_ok && cmd_ok;
        pos.cx = mx[CX_W-1:0];
        pos.cy = my[CY_W-1:0];
    end

endmodule

FILE: hw/rtl/ogeu_eval.sv
// Classifies an updated cell: ratio products are registered, then compared.
// Depends on ogeu_pkg.
module ogeu_eval (
    input  logic                      clk,
    input  ogeu_pkg::cell_entry_t     entry,
    input  logic [7:0]                ratio_num,
    input  logic [7:0]                ratio_den,
    output ogeu_pkg::cell_class_t     cls
);
    import ogeu_pkg::*;

    logic [PROD_W-1:0] wall_prod_reg;
    logic [PROD_W-1:0] ground_prod_reg;
    logic              visited_reg;

    // Register both weighted counts
    always_ff @(posedge clk)
    begin
        wall_prod_reg   <= PROD_W'(entry.wall) * PROD_W'(ratio_den);
        ground_prod_reg <= PROD_W'(entry.ground) * PROD_W'(ratio_num);
        visited_reg     <= (entry.visit != '0);
    end

    // Ground if ever visited or wall evidence is at or under the threshold
    always_comb
    begin
        if (visited_reg || (wall_prod_reg <= ground_prod_reg))
        begin
            cls = CLS_GROUND;
        end
        else
        begin
            cls = CLS_WALL;
        end
    end

endmodule

FILE: hw/rtl/occupancy_grid_evidence_update_core.sv
// Top level of the occupancy grid evidence update core: controller, config registers,
// output register. Uses ogeu_pkg, ogeu_coord, ogeu_cell_ram and ogeu_eval.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  in       | in_valid, in_ready, command, pos_x, pos_y | sink
//  out      | out_valid, out_ready, accepted, cell_x,   | source
//           | cell_y, cell_state, last_x, last_y        |
//  cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | sink
//
// Each transaction runs through accept, memory read, counter update, ratio multiply,
// compare and write back; the single read-modify-write of the cell store sets this order.
// After reset a clearing pass writes all 25088 cells, one a cycle; in_ready stays low for it.
// Config writes are taken every cycle. A held result stalls only the write-back step;
// the next transaction is accepted while the result waits.
module occupancy_grid_evidence_update_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            command,
    input  logic signed [15:0]    pos_x,
    input  logic signed [15:0]    pos_y,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  accepted,
    output logic [7:0]            cell_x,
    output logic [6:0]            cell_y,
    output logic [1:0]            cell_state,
    output logic [7:0]            last_x,
    output logic [6:0]            last_y,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [0:0]            cfg_index,
    input  logic [7:0]            cfg_data
);
    import ogeu_pkg::*;

    ctrl_state_t             state_reg;
    ctrl_state_t             state_next;
    logic [CELL_ADDR_W-1:0]  clr_cnt_reg;
    logic [RATIO_W-1:0]      ratio_num_reg;
    logic [RATIO_W-1:0]      ratio_den_reg;

    cell_pos_t               pos_in;
    cell_pos_t               pos_reg;
    logic [1:0]              cmd_reg;
    logic [CELL_ADDR_W-1:0]  addr;

    logic                    ram_we;
    logic                    ram_re;
    logic [CELL_ADDR_W-1:0]  ram_waddr;
    logic [ENTRY_W-1:0]      ram_wdata;
    logic [ENTRY_W-1:0]      ram_rdata;
    cell_entry_t             rd_entry;
    cell_entry_t             mod_reg;
    cell_entry_t             mod_next;
    cell_entry_t             wr_entry;
    cell_class_t             new_cls;

    logic                    out_free;
    logic                    wb_fire;
    logic                    in_fire;
    logic                    clr_last;

    logic                    out_valid_reg;
    logic                    accepted_reg;
    logic [CX_W-1:0]         cell_x_reg;
    logic [CY_W-1:0]         cell_y_reg;
    cell_class_t             cell_state_reg;
    logic [CX_W-1:0]         last_x_reg;
    logic [CY_W-1:0]         last_y_reg;

    // Map the incoming position
    ogeu_coord u_coord (
        .command (command),
        .pos_x   (pos_x),
        .pos_y   (pos_y),
        .pos     (pos_in)
    );

    ogeu_cell_ram #(
        .DEPTH  (CELLS),
        .WIDTH  (ENTRY_W),
        .ADDR_W (CELL_ADDR_W)
    ) u_cell_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    ogeu_eval u_eval (
        .clk       (clk),
        .entry     (mod_reg),
        .ratio_num (ratio_num_reg),
        .ratio_den (ratio_den_reg),
        .cls       (new_cls)
    );

    // Cell address, column-major
    assign addr = CELL_ADDR_W'(pos_reg.cx * GRID_H) + CELL_ADDR_W'(pos_reg.cy);

    assign out_free = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign clr_last = (clr_cnt_reg == CELL_ADDR_W'(CELLS - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:   state_next = ST_MODIFY;
            ST_MODIFY: state_next = ST_MULT;
            ST_MULT:   state_next = ST_WRITE;
            ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Controller outputs
    always_comb
    begin
        in_ready = 1'b0;
        ram_re   = 1'b0;
        ram_we   = 1'b0;
        wb_fire  = 1'b0;
        case (state_reg)
            ST_CLEAR:  ram_we = 1'b1;
            ST_IDLE:   in_ready = 1'b1;
            ST_READ:   ram_re = 1'b1;
            ST_MODIFY: ;
            ST_MULT:   ;
            ST_WRITE:
            begin
                wb_fire = out_free;
                ram_we  = out_free && pos_reg.ok;
            end
            default:   ;
        endcase
    end

    // Write data: zeros during the clearing pass, else the updated entry
    always_comb
    begin
        wr_entry     = mod_reg;
        wr_entry.cls = new_cls;
        if (state_reg == ST_CLEAR)
        begin
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_waddr = addr;
            ram_wdata = ENTRY_W'(wr_entry);
        end
    end

    // Increment the selected counter
    always_comb
    begin
        rd_entry = cell_entry_t'(ram_rdata);
        mod_next = rd_entry;
        case (cmd_reg)
            CMD_WALL:   mod_next.wall   = sat_inc(rd_entry.wall);
            CMD_GROUND: mod_next.ground = sat_inc(rd_entry.ground);
            CMD_VISIT:  mod_next.visit  = sat_inc(rd_entry.visit);
            default:    mod_next = rd_entry;
        endcase
    end

    // Controller state and clearing counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR && !clr_last)
            begin
                clr_cnt_reg <= clr_cnt_reg + CELL_ADDR_W'(1);
            end
        end
    end

    // Capture the transaction and the modified entry
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pos_reg <= pos_in;
            cmd_reg <= command;
        end
        if (state_reg == ST_MODIFY)
        begin
            mod_reg <= mod_next;
        end
    end

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_num_reg <= RATIO_NUM_RST;
            ratio_den_reg <= RATIO_DEN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_RATIO_NUM: ratio_num_reg <= cfg_data;
                CFG_RATIO_DEN: ratio_den_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Output register and last visited cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            last_x_reg    <= ORIGIN_X;
            last_y_reg    <= ORIGIN_Y;
        end
        else
        begin
            if (wb_fire)
            begin
                out_valid_reg <= 1'b1;
                if (pos_reg.ok && cmd_reg == CMD_VISIT)
                begin
                    last_x_reg <= pos_reg.cx;
                    last_y_reg <= pos_reg.cy;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload; rejected items report zeros
    always_ff @(posedge clk)
    begin
        if (wb_fire)
        begin
            accepted_reg   <= pos_reg.ok;
            cell_x_reg     <= pos_reg.ok ? pos_reg.cx : '0;
            cell_y_reg     <= pos_reg.ok ? pos_reg.cy : '0;
            cell_state_reg <= pos_reg.ok ? new_cls : CLS_UNKNOWN;
        end
    end

    assign out_valid  = out_valid_reg;
    assign accepted   = accepted_reg;
    assign cell_x     = cell_x_reg;
    assign cell_y     = cell_y_reg;
    assign cell_state = cell_state_reg;
    assign last_x     = last_x_reg;
    assign last_y     = last_y_reg;

`ifndef SYNTHESIS
    // No item write-back while new transactions are taken
    a_no_write_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !ram_we)
        else $error("cell store written while accepting");

    // Item writes only for positions on the grid
    a_write_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg != ST_CLEAR) |-> pos_reg.ok)
        else $error("rejected position written to cell store");

    // Applied results stay on the grid and carry a real class
    a_applied_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && accepted) |->
            (cell_x < CX_W'(GRID_W)) && (cell_y < CY_W'(GRID_H)) &&
            (cell_state == CLS_GROUND || cell_state == CLS_WALL))
        else $error("bad applied result");

    // Rejected results report zeros
    a_rejected_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !accepted) |->
            (cell_x == '0) && (cell_y == '0) && (cell_state == CLS_UNKNOWN))
        else $error("rejected result not cleared");
`endif

endmodule
